/* hdl/sobel_pkg.sv */
// Shared types and constants for the Sobel edge magnitude core.
package sobel_pkg;

    typedef logic [2:0][7:0] rgb_t;

    typedef struct packed {
        logic start;
        logic ack;
    } mag_ctrl_t;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    localparam int  TAPS = 9;
    localparam logic [3:0] TAP_LAST = 4'd8;

    localparam logic [1:0] TAP_ROW [TAPS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                              2'd2, 2'd2, 2'd2};
    localparam logic [1:0] TAP_COL [TAPS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                              2'd0, 2'd1, 2'd2};

    localparam logic [1:0] OFS_LOW  = 2'd0;
    localparam logic [1:0] OFS_HIGH = 2'd2;

    localparam logic [20:0] ROOT_START_BIT = 21'h100000;
    localparam logic [7:0]  EDGE_MAX       = 8'd255;

endpackage

/* hdl/sobel_edge_magnitude_rgb_core.sv */
// Top level of the streaming RGB Sobel edge magnitude core.
// Pixels enter in raster order; each result is round(sqrt(Gx^2+Gy^2)) clamped to 255
// per channel, neighbours outside the frame counted as zero, emitted one row plus one
// pixel behind the input; flush beats drain the tail of a frame and the frame's last
// result carries end_of_frame. An item that yields no result is only checked; one that
// yields a result has its nine taps fetched through the single read port
// of the row buffer memory, then gradients, squares and an 11-step square root shared
// by the three channels. A finished result waits in the output register while the next
// item is taken. Writing either register restarts the stream.
module sobel_edge_magnitude_rgb_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_pixel_red,
    input  logic [7:0]  s_pixel_green,
    input  logic [7:0]  s_pixel_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_edge_red,
    output logic [7:0]  m_edge_green,
    output logic [7:0]  m_edge_blue,
    output logic        m_end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int EW = (WW > 12) ? WW : 12;
    localparam int PW = WW + 1;
    localparam int AW = CW + 2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_READ  = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_START = 6'b010000,
        ST_MAG   = 6'b100000
    } core_state_t;

    core_state_t state_reg, state_next;

    logic [11:0] frame_width_reg, frame_height_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [11:0] in_row_reg, out_row_reg;
    logic [1:0] in_slot_reg, out_slot_reg;
    logic [PW-1:0] pending_reg;
    logic [1:0] ahead_reg;
    logic [3:0] tap_reg;
    logic [3:0] rd_tap_reg;
    logic rd_mask_reg, rd_valid_reg;
    sobel_pkg::rgb_t window_reg [sobel_pkg::TAPS];
    logic m_valid_reg;
    sobel_pkg::rgb_t m_edge_reg;
    logic m_eof_reg;

    logic [EW-1:0] fw_ext;
    logic [WW-1:0] eff_w;
    logic [11:0] eff_h;
    logic cfg_wr, accept, pixel_in, ready_out, emit;
    logic [AW-1:0] rd_addr;
    logic tap_mask;
    sobel_pkg::rgb_t rd_data, pix;
    sobel_pkg::mag_ctrl_t mag_ctrl;
    logic mag_done;
    sobel_pkg::rgb_t mag_edge;

    assign fw_ext = EW'(frame_width_reg);
    always_comb begin
        if (fw_ext == '0) begin
            eff_w = WW'(1);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(fw_ext);
        end
    end
    assign eff_h = (frame_height_reg == '0) ? 12'd1 : frame_height_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == sobel_pkg::REG_FRAME_HEIGHT) ? {20'b0, frame_height_reg}
                                                              : {20'b0, frame_width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= sobel_pkg::WIDTH_RESET;
            frame_height_reg <= sobel_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == sobel_pkg::REG_FRAME_WIDTH) begin
                frame_width_reg <= pwdata[11:0];
            end else begin
                frame_height_reg <= pwdata[11:0];
            end
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign pixel_in = accept && (s_action == sobel_pkg::ACTION_PIXEL);
    assign pix      = {s_pixel_blue, s_pixel_green, s_pixel_red};

    assign ready_out = (pending_reg != '0) &&
                       ((ahead_reg != '0) || (pending_reg >= PW'(eff_w) + PW'(1)));
    assign emit = (state_reg == ST_MAG) && mag_done && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_CHECK;
            ST_CHECK: state_next = ready_out ? ST_READ : ST_IDLE;
            ST_READ:  if (tap_reg == sobel_pkg::TAP_LAST) state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_START;
            ST_START: state_next = ST_MAG;
            ST_MAG:   if (emit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_READ && tap_reg != sobel_pkg::TAP_LAST) begin
                tap_reg <= tap_reg + 4'd1;
            end else begin
                tap_reg <= '0;
            end
        end
    end

    // advance input and output positions
    always_ff @(posedge aclk) begin
        logic [CW:0] col_inc;
        logic [12:0] row_inc;
        logic [1:0] ahead_v;
        logic [PW-1:0] pend_v;
        col_inc = '0;
        row_inc = '0;
        if (!aresetn || cfg_wr) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            pending_reg  <= '0;
            ahead_reg    <= '0;
        end else begin
            ahead_v = ahead_reg;
            pend_v  = pending_reg;
            if (pixel_in) begin
                pend_v  = pend_v + PW'(1);
                col_inc = {1'b0, in_col_reg} + (CW+1)'(1);
                if (WW'(col_inc) >= eff_w) begin
                    in_col_reg  <= '0;
                    in_slot_reg <= in_slot_reg + 2'd1;
                    row_inc = {1'b0, in_row_reg} + 13'd1;
                    if (row_inc >= {1'b0, eff_h}) begin
                        in_row_reg <= '0;
                        ahead_v = ahead_v + 2'd1;
                    end else begin
                        in_row_reg <= row_inc[11:0];
                    end
                end else begin
                    in_col_reg <= col_inc[CW-1:0];
                end
            end
            if (emit) begin
                pend_v  = pend_v - PW'(1);
                col_inc = {1'b0, out_col_reg} + (CW+1)'(1);
                if (WW'(col_inc) >= eff_w) begin
                    out_col_reg  <= '0;
                    out_slot_reg <= out_slot_reg + 2'd1;
                    row_inc = {1'b0, out_row_reg} + 13'd1;
                    if (row_inc >= {1'b0, eff_h}) begin
                        out_row_reg <= '0;
                        if (ahead_v != '0) ahead_v = ahead_v - 2'd1;
                    end else begin
                        out_row_reg <= row_inc[11:0];
                    end
                end else begin
                    out_col_reg <= col_inc[CW-1:0];
                end
            end
            ahead_reg   <= ahead_v;
            pending_reg <= pend_v;
        end
    end

    always_comb begin
        logic [1:0] ti, tj;
        logic row_ok, col_ok;
        ti = sobel_pkg::TAP_ROW[tap_reg];
        tj = sobel_pkg::TAP_COL[tap_reg];
        rd_addr = {out_slot_reg + ti + 2'd3, out_col_reg + CW'(tj) - CW'(1)};
        priority if (ti == sobel_pkg::OFS_LOW) begin
            row_ok = (out_row_reg != '0);
        end else if (ti == sobel_pkg::OFS_HIGH) begin
            row_ok = ({1'b0, out_row_reg} + 13'd1) < {1'b0, eff_h};
        end else begin
            row_ok = 1'b1;
        end
        priority if (tj == sobel_pkg::OFS_LOW) begin
            col_ok = (out_col_reg != '0);
        end else if (tj == sobel_pkg::OFS_HIGH) begin
            col_ok = (WW'(out_col_reg) + WW'(1)) < eff_w;
        end else begin
            col_ok = 1'b1;
        end
        tap_mask = row_ok && col_ok;
    end

    sobel_line_mem #(
        .ADDR_BITS(AW)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (pixel_in),
        .wr_addr ({in_slot_reg, in_col_reg}),
        .wr_data (pix),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_READ);
        end
        rd_tap_reg  <= tap_reg;
        rd_mask_reg <= tap_mask;
        if (rd_valid_reg) begin
            window_reg[rd_tap_reg] <= rd_mask_reg ? rd_data : '0;
        end
    end

    assign mag_ctrl.start = (state_reg == ST_START);
    assign mag_ctrl.ack   = emit;

    sobel_mag u_mag (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mag_ctrl),
        .window   (window_reg),
        .done     (mag_done),
        .edge_out (mag_edge)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit) begin
            m_edge_reg <= mag_edge;
            m_eof_reg  <= ({1'b0, out_row_reg} + 13'd1 == {1'b0, eff_h}) &&
                          (WW'(out_col_reg) + WW'(1) == eff_w);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_edge_red     = m_edge_reg[0];
    assign m_edge_green   = m_edge_reg[1];
    assign m_edge_blue    = m_edge_reg[2];
    assign m_end_of_frame = m_eof_reg;

endmodule

/* hdl/sobel_line_mem.sv */
// Row buffer memory: one write port, one registered read port.
module sobel_line_mem #(
    parameter int ADDR_BITS = 13
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  sobel_pkg::rgb_t       wr_data,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output sobel_pkg::rgb_t       rd_data
);

    sobel_pkg::rgb_t mem [0:(1 << ADDR_BITS)-1];
    sobel_pkg::rgb_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/sobel_mag.sv */
// Gradient, squared sum and iterative rounded square root for three channels.
module sobel_mag (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sobel_pkg::mag_ctrl_t  ctrl,
    input  sobel_pkg::rgb_t       window [sobel_pkg::TAPS],
    output logic                  done,
    output sobel_pkg::rgb_t       edge_out
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_GRAD = 5'b00010,
        M_SQR  = 5'b00100,
        M_ROOT = 5'b01000,
        M_DONE = 5'b10000
    } mag_state_t;

    mag_state_t state_reg, state_next;

    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];
    logic signed [10:0] gx_next [3];
    logic signed [10:0] gy_next [3];
    logic [20:0] rem_reg [3];
    logic [20:0] res_reg [3];
    logic [20:0] bit_reg;

    always_comb begin
        logic [9:0] px, nx, py, ny;
        for (int ch = 0; ch < 3; ch++) begin
            px = {2'b0, window[2][ch]} + {1'b0, window[5][ch], 1'b0} + {2'b0, window[8][ch]};
            nx = {2'b0, window[0][ch]} + {1'b0, window[3][ch], 1'b0} + {2'b0, window[6][ch]};
            py = {2'b0, window[6][ch]} + {1'b0, window[7][ch], 1'b0} + {2'b0, window[8][ch]};
            ny = {2'b0, window[0][ch]} + {1'b0, window[1][ch], 1'b0} + {2'b0, window[2][ch]};
            gx_next[ch] = $signed({1'b0, px}) - $signed({1'b0, nx});
            gy_next[ch] = $signed({1'b0, py}) - $signed({1'b0, ny});
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE: if (ctrl.start) state_next = M_GRAD;
            M_GRAD: state_next = M_SQR;
            M_SQR:  state_next = M_ROOT;
            M_ROOT: if (bit_reg[0]) state_next = M_DONE;
            M_DONE: if (ctrl.ack) state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [21:0] sqx, sqy;
        logic [21:0] trial;
        sqx = '0;
        sqy = '0;
        trial = '0;
        unique case (state_reg)
            M_GRAD: begin
                for (int ch = 0; ch < 3; ch++) begin
                    gx_reg[ch] <= gx_next[ch];
                    gy_reg[ch] <= gy_next[ch];
                end
            end
            M_SQR: begin
                for (int ch = 0; ch < 3; ch++) begin
                    sqx = gx_reg[ch] * gx_reg[ch];
                    sqy = gy_reg[ch] * gy_reg[ch];
                    rem_reg[ch] <= sqx[20:0] + sqy[20:0];
                    res_reg[ch] <= '0;
                end
                bit_reg <= sobel_pkg::ROOT_START_BIT;
            end
            M_ROOT: begin
                for (int ch = 0; ch < 3; ch++) begin
                    trial = {1'b0, res_reg[ch]} + {1'b0, bit_reg};
                    if ({1'b0, rem_reg[ch]} >= trial) begin
                        rem_reg[ch] <= rem_reg[ch] - trial[20:0];
                        res_reg[ch] <= (res_reg[ch] >> 1) + bit_reg;
                    end else begin
                        res_reg[ch] <= res_reg[ch] >> 1;
                    end
                end
                bit_reg <= bit_reg >> 2;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic [11:0] r;
        r = '0;
        for (int ch = 0; ch < 3; ch++) begin
            r = {1'b0, res_reg[ch][10:0]} + 12'(rem_reg[ch] > res_reg[ch]);
            edge_out[ch] = (r > 12'(sobel_pkg::EDGE_MAX)) ? sobel_pkg::EDGE_MAX : r[7:0];
        end
    end

    assign done = (state_reg == M_DONE);

endmodule
